// ----- hw/rtl/rob_pkg.sv -----
`default_nettype none

package rob_pkg;

  // Field widths of the words on the ports.
  localparam int POS_W  = 24;   // Q16.8 positions
  localparam int EXT_W  = 23;   // Q15.8 box extents
  localparam int AX_W   = 16;   // Q2.14 axis components
  localparam int DIR_W  = 16;   // Q2.14 ray direction
  localparam int IDX_W  = 10;   // box order number
  localparam int DIST_W = 23;   // Q15.8 distance on the result
  localparam int BEST_W = 24;   // kept best distance

  // Internal datapath widths.
  localparam int DIFF_W = POS_W + 1;        // difference of two positions
  localparam int MUL_W  = 26;               // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;        // shared multiplier product
  localparam int H_W    = EXT_W + 13;       // half extent in Q.22
  localparam int E_W    = 42;               // projected centre offset in Q.22
  localparam int P_W    = 32;               // projected direction in Q.28
  localparam int SQ_W   = 50;               // squared ray length
  localparam int LEN_W  = 25;               // ray length before saturation
  localparam int NUM_W  = 55;               // divider dividend
  localparam int DEN_W  = 30;               // divider divisor
  localparam int QUO_W  = 25;               // divider quotient bits
  localparam int T_W    = 26;               // saturated slab parameter
  localparam int DIR_FRAC = 14;             // fraction bits of the direction

  localparam int ROOT_STEPS = LEN_W;
  localparam logic [IDX_W-1:0]  INDEX_CAP = 10'd1023;
  localparam logic [DIST_W-1:0] DIST_MAX  = 23'h7F_FFFF;
  localparam logic [BEST_W-1:0] BEST_RESET = 24'hFF_FFFF;
  // Slab parameters are clamped to this magnitude; it lies above any ray length.
  localparam logic signed [T_W-1:0] T_LIMIT = 26'sd16777216;
  localparam logic [QUO_W-1:0] QUO_LIMIT = 25'h100_0000;
  localparam logic signed [POS_W+1:0] POS_MAX = 26'sd8388607;
  localparam logic signed [POS_W+1:0] POS_MIN = -26'sd8388608;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [EXT_W-1:0]        width;
    logic [EXT_W-1:0]        height;
    logic signed [AX_W-1:0]  cos_v;
    logic signed [AX_W-1:0]  sin_v;
    logic                    blocks;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                    load;
    logic                    found;
    logic [IDX_W-1:0]        index;
    logic [DIST_W-1:0]       distance;
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rob_front.sv -----
`default_nettype none

// Accepts words, classifies them by action and holds them in a two-entry queue.
module rob_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           valid,
  output logic                                stall,
  input  wire logic [1:0]                     action,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_start_x,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_start_y,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_end_x,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_end_y,
  input  wire logic signed [rob_pkg::POS_W-1:0] box_center_x,
  input  wire logic signed [rob_pkg::POS_W-1:0] box_center_y,
  input  wire logic [rob_pkg::EXT_W-1:0]      box_width,
  input  wire logic [rob_pkg::EXT_W-1:0]      box_height,
  input  wire logic signed [rob_pkg::AX_W-1:0] axis_cos,
  input  wire logic signed [rob_pkg::AX_W-1:0] axis_sin,
  input  wire logic                           box_blocks,
  output logic                                q_valid,
  output rob_pkg::item_t                      q_item,
  input  wire logic                           q_pop
);

  rob_pkg::item_t slots [2];
  rob_pkg::item_t incoming;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;

  always_comb begin
    incoming.kind     = rob_pkg::kind_t'(action);
    incoming.start_x  = ray_start_x;
    incoming.start_y  = ray_start_y;
    incoming.end_x    = ray_end_x;
    incoming.end_y    = ray_end_y;
    incoming.center_x = box_center_x;
    incoming.center_y = box_center_y;
    incoming.width    = box_width;
    incoming.height   = box_height;
    incoming.cos_v    = axis_cos;
    incoming.sin_v    = axis_sin;
    incoming.blocks   = box_blocks;
  end

  assign stall   = (fill == 2'd2);
  // Words with the unused action code are taken and dropped here.
  assign push    = valid && !stall && (incoming.kind != rob_pkg::KIND_NONE);
  assign q_valid = (fill != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rob_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle. Quotients that do not fit in
// QUO_W bits come back as all ones.
module rob_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rob_pkg::div_req_t req,
  output rob_pkg::div_rsp_t      rsp
);

  logic                        busy;
  logic                        done;
  logic [4:0]                  cnt;
  logic [rob_pkg::DEN_W-1:0]   rem;
  logic [rob_pkg::QUO_W-1:0]   nlo;
  logic [rob_pkg::DEN_W-1:0]   den;
  logic [rob_pkg::QUO_W-1:0]   quot;
  logic                        ovf;
  logic [rob_pkg::DEN_W:0]     trial;
  logic [rob_pkg::DEN_W:0]     diff;
  logic                        ge;

  assign trial = {rem, nlo[rob_pkg::QUO_W-1]};
  assign ge    = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(rob_pkg::QUO_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num[rob_pkg::NUM_W-1:rob_pkg::QUO_W];
      nlo  <= req.num[rob_pkg::QUO_W-1:0];
      den  <= req.den;
      ovf  <= (req.num[rob_pkg::NUM_W-1:rob_pkg::QUO_W] >= req.den);
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[rob_pkg::DEN_W-1:0] : trial[rob_pkg::DEN_W-1:0];
      nlo  <= {nlo[rob_pkg::QUO_W-2:0], 1'b0};
      quot <= {quot[rob_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = ovf ? '1 : quot;

endmodule

`default_nettype wire

// ----- hw/rtl/rob_engine.sv -----
`default_nettype none

// Back end: carries out begin, box and finish words one at a time.
module rob_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire rob_pkg::item_t    q_item,
  output logic                   q_pop,
  input  wire logic              out_free,
  output rob_pkg::res_t          res,
  output rob_pkg::div_req_t      div_req,
  input  wire rob_pkg::div_rsp_t div_rsp
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SQ      = 9'b000000010,
    S_ROOT    = 9'b000000100,
    S_DIRDIV  = 9'b000001000,
    S_MUL     = 9'b000010000,
    S_AXIS    = 9'b000100000,
    S_SLABDIV = 9'b001000000,
    S_DECIDE  = 9'b010000000,
    S_POINT   = 9'b100000000
  } state_t;

  state_t state;
  logic [3:0] k;
  logic [4:0] cnt;
  logic       sel;
  logic       sub;

  // Query state.
  logic signed [rob_pkg::POS_W-1:0] origin_x, origin_y;
  logic signed [rob_pkg::DIR_W-1:0] dir_x, dir_y;
  logic [rob_pkg::DIST_W-1:0]       ray_length;
  logic [rob_pkg::BEST_W-1:0]       best_distance;
  logic [rob_pkg::IDX_W-1:0]        best_box;
  logic                             any_hit;
  logic [rob_pkg::IDX_W-1:0]        box_counter;
  logic signed [rob_pkg::POS_W-1:0] best_point_x, best_point_y;

  // Working registers.
  logic signed [rob_pkg::DIFF_W-1:0] dx, dy;
  logic [rob_pkg::SQ_W-1:0]          sq_n, root, root_bit;
  logic [rob_pkg::LEN_W-1:0]         len;
  logic [rob_pkg::IDX_W-1:0]         idx;
  logic signed [rob_pkg::DIFF_W-1:0] cx, cy;
  logic signed [rob_pkg::AX_W-1:0]   cs, sn;
  logic [rob_pkg::H_W-1:0]           hx, hy;
  logic signed [rob_pkg::E_W-1:0]    ex, ey, acc;
  logic signed [rob_pkg::P_W-1:0]    px, py;
  logic signed [rob_pkg::PROD_W-1:0] prod;
  logic signed [rob_pkg::T_W-1:0]    lo_x, hi_x, lo_y, hi_y, ta;
  logic [rob_pkg::DIST_W-1:0]        dist_r;

  // Combinational values.
  logic signed [rob_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [rob_pkg::PROD_W-1:0] mul_p;
  logic [rob_pkg::DIFF_W-1:0]        ax_mag, ay_mag, dmag;
  logic [rob_pkg::LEN_W-1:0]         len_use;
  logic [39:0]                       dir_num;
  logic signed [rob_pkg::E_W-1:0]    e_sel, h_sel, e_plus, e_minus, n_start, n_res, n_mag;
  logic signed [rob_pkg::P_W-1:0]    p_sel, p_mag;
  logic                              outside;
  logic                              neg;
  logic [rob_pkg::QUO_W-1:0]         q_sat;
  logic signed [rob_pkg::T_W-1:0]    t_mag, t_val, t_lo, t_hi;
  logic signed [rob_pkg::T_W-1:0]    tmin, tmax, t_hit;
  logic                              take_hit;
  logic signed [rob_pkg::E_W-1:0]    pe;
  logic [rob_pkg::SQ_W-1:0]          trial;
  logic [3:0]                        j;
  logic [rob_pkg::DIR_W-1:0]         q_dir;

  function automatic logic signed [rob_pkg::POS_W-1:0] place(
      input logic signed [rob_pkg::PROD_W-1:0] pr,
      input logic signed [rob_pkg::POS_W-1:0]  org);
    logic [rob_pkg::PROD_W-1:0]         mg;
    logic [rob_pkg::PROD_W-1:0]         rn;
    logic signed [rob_pkg::POS_W+1:0]   step;
    logic signed [rob_pkg::POS_W+1:0]   sum;
    mg   = pr[rob_pkg::PROD_W-1] ? rob_pkg::PROD_W'(-pr) : rob_pkg::PROD_W'(pr);
    rn   = (mg + rob_pkg::PROD_W'(8192)) >> rob_pkg::DIR_FRAC;
    step = $signed({1'b0, rn[rob_pkg::POS_W:0]});
    sum  = $signed({{2{org[rob_pkg::POS_W-1]}}, org})
           + (pr[rob_pkg::PROD_W-1] ? -step : step);
    if (sum > rob_pkg::POS_MAX) begin
      place = rob_pkg::POS_MAX[rob_pkg::POS_W-1:0];
    end else if (sum < rob_pkg::POS_MIN) begin
      place = rob_pkg::POS_MIN[rob_pkg::POS_W-1:0];
    end else begin
      place = sum[rob_pkg::POS_W-1:0];
    end
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid &&
                 ((q_item.kind != rob_pkg::KIND_FINISH) || out_free);

  always_comb begin
    res.load     = q_pop && (q_item.kind == rob_pkg::KIND_FINISH);
    res.found    = any_hit;
    res.index    = any_hit ? best_box : '0;
    res.distance = any_hit ? best_distance[rob_pkg::DIST_W-1:0] : '0;
    res.point_x  = any_hit ? best_point_x : '0;
    res.point_y  = any_hit ? best_point_y : '0;
  end

  assign ax_mag = dx[rob_pkg::DIFF_W-1] ? rob_pkg::DIFF_W'(-dx) : rob_pkg::DIFF_W'(dx);
  assign ay_mag = dy[rob_pkg::DIFF_W-1] ? rob_pkg::DIFF_W'(-dy) : rob_pkg::DIFF_W'(dy);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = (k == 4'd0) ? $signed({1'b0, ax_mag}) : $signed({1'b0, ay_mag});
        mul_b = mul_a;
      end
      S_MUL: begin
        case (k[2:0])
          3'd0: begin mul_a = {cx[24], cx}; mul_b = {{10{cs[15]}}, cs}; end
          3'd1: begin mul_a = {cy[24], cy}; mul_b = {{10{sn[15]}}, sn}; end
          3'd2: begin mul_a = {cy[24], cy}; mul_b = {{10{cs[15]}}, cs}; end
          3'd3: begin mul_a = {cx[24], cx}; mul_b = {{10{sn[15]}}, sn}; end
          3'd4: begin mul_a = {{10{dir_x[15]}}, dir_x}; mul_b = {{10{cs[15]}}, cs}; end
          3'd5: begin mul_a = {{10{dir_y[15]}}, dir_y}; mul_b = {{10{sn[15]}}, sn}; end
          3'd6: begin mul_a = {{10{dir_y[15]}}, dir_y}; mul_b = {{10{cs[15]}}, cs}; end
          default: begin mul_a = {{10{dir_x[15]}}, dir_x}; mul_b = {{10{sn[15]}}, sn}; end
        endcase
      end
      S_POINT: begin
        mul_a = (k == 4'd0) ? {{10{dir_x[15]}}, dir_x} : {{10{dir_y[15]}}, dir_y};
        mul_b = $signed({3'b000, dist_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Slab arithmetic for the axis under test.
  always_comb begin
    e_sel   = sel ? ey : ex;
    h_sel   = $signed({6'b000000, (sel ? hy : hx)});
    p_sel   = sel ? py : px;
    e_plus  = e_sel + h_sel;
    e_minus = e_sel - h_sel;
    outside = (e_sel < -h_sel) || (e_sel > h_sel);
    n_start = (state == S_SLABDIV) ? e_minus : e_plus;
    n_mag   = n_start[rob_pkg::E_W-1] ? -n_start : n_start;
    p_mag   = p_sel[rob_pkg::P_W-1] ? -p_sel : p_sel;
    n_res   = sub ? e_minus : e_plus;
    neg     = n_res[rob_pkg::E_W-1] ^ p_sel[rob_pkg::P_W-1];
    q_sat   = (div_rsp.quot > rob_pkg::QUO_LIMIT) ? rob_pkg::QUO_LIMIT : div_rsp.quot;
    t_mag   = $signed({1'b0, q_sat});
    t_val   = neg ? -t_mag : t_mag;
    t_lo    = (ta < t_val) ? ta : t_val;
    t_hi    = (ta < t_val) ? t_val : ta;
  end

  // Direction division: (|d| << 15 + len) / (len << 1).
  always_comb begin
    len_use = (state == S_ROOT) ? root[rob_pkg::LEN_W-1:0] : len;
    dmag    = (state == S_ROOT) ? ax_mag : ay_mag;
    dir_num = {dmag, 15'b0} + {15'b0, len_use};
    q_dir   = div_rsp.quot[rob_pkg::DIR_W-1:0];
  end

  always_comb begin
    div_req.start = ((state == S_AXIS) && (p_sel != '0)) ||
                    ((state == S_SLABDIV) && div_rsp.done && !sub) ||
                    ((state == S_ROOT) && (cnt == 5'd0) && (root[rob_pkg::LEN_W-1:0] != '0)) ||
                    ((state == S_DIRDIV) && div_rsp.done && !sel);
    if ((state == S_ROOT) || (state == S_DIRDIV)) begin
      div_req.num = {15'b0, dir_num};
      div_req.den = {4'b0000, len_use, 1'b0};
    end else begin
      div_req.num = {n_mag[40:0], 14'b0};
      div_req.den = p_mag[rob_pkg::DEN_W-1:0];
    end
  end

  // Interval combination and acceptance of a hit.
  always_comb begin
    tmin     = (lo_x > lo_y) ? lo_x : lo_y;
    tmax     = (hi_x < hi_y) ? hi_x : hi_y;
    t_hit    = (tmin < 0) ? tmax : tmin;
    take_hit = !(tmin > tmax) && (t_hit > 0) &&
               (t_hit <= $signed({3'b000, ray_length})) &&
               (t_hit < $signed({2'b00, best_distance}));
  end

  assign pe    = prod[rob_pkg::E_W-1:0];
  assign trial = root + root_bit;
  assign j     = k - 4'd1;

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state         <= S_IDLE;
      k             <= '0;
      cnt           <= '0;
      sel           <= 1'b0;
      sub           <= 1'b0;
      origin_x      <= '0;
      origin_y      <= '0;
      dir_x         <= '0;
      dir_y         <= '0;
      ray_length    <= '0;
      best_distance <= rob_pkg::BEST_RESET;
      best_box      <= '0;
      any_hit       <= 1'b0;
      box_counter   <= '0;
      best_point_x  <= '0;
      best_point_y  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.kind)
              rob_pkg::KIND_BEGIN: begin
                origin_x      <= q_item.start_x;
                origin_y      <= q_item.start_y;
                dx            <= {q_item.end_x[23], q_item.end_x}
                                 - {q_item.start_x[23], q_item.start_x};
                dy            <= {q_item.end_y[23], q_item.end_y}
                                 - {q_item.start_y[23], q_item.start_y};
                best_distance <= rob_pkg::BEST_RESET;
                best_box      <= '0;
                any_hit       <= 1'b0;
                box_counter   <= '0;
                best_point_x  <= '0;
                best_point_y  <= '0;
                k             <= '0;
                state         <= S_SQ;
              end
              rob_pkg::KIND_BOX: begin
                idx <= box_counter;
                if (box_counter < rob_pkg::INDEX_CAP) begin
                  box_counter <= box_counter + 10'd1;
                end
                if (q_item.blocks && (ray_length != '0)) begin
                  cx    <= {q_item.center_x[23], q_item.center_x} - {origin_x[23], origin_x};
                  cy    <= {q_item.center_y[23], q_item.center_y} - {origin_y[23], origin_y};
                  cs    <= q_item.cos_v;
                  sn    <= q_item.sin_v;
                  hx    <= {q_item.width, 13'b0};
                  hy    <= {q_item.height, 13'b0};
                  k     <= '0;
                  state <= S_MUL;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SQ: begin
          k <= k + 4'd1;
          if (k == 4'd1) begin
            sq_n <= prod[rob_pkg::SQ_W-1:0];
          end else if (k == 4'd2) begin
            sq_n     <= sq_n + prod[rob_pkg::SQ_W-1:0];
            root     <= '0;
            root_bit <= rob_pkg::SQ_W'(1) << 48;
            cnt      <= 5'(rob_pkg::ROOT_STEPS);
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (cnt != 5'd0) begin
            if (sq_n >= trial) begin
              sq_n <= sq_n - trial;
              root <= (root >> 1) + root_bit;
            end else begin
              root <= root >> 1;
            end
            root_bit <= root_bit >> 2;
            cnt      <= cnt - 5'd1;
          end else begin
            len <= root[rob_pkg::LEN_W-1:0];
            if (root[rob_pkg::LEN_W-1:0] > {2'b00, rob_pkg::DIST_MAX}) begin
              ray_length <= rob_pkg::DIST_MAX;
            end else begin
              ray_length <= root[rob_pkg::DIST_W-1:0];
            end
            sel <= 1'b0;
            if (root[rob_pkg::LEN_W-1:0] == '0) begin
              dir_x <= '0;
              dir_y <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_DIRDIV;
            end
          end
        end
        S_DIRDIV: begin
          if (div_rsp.done) begin
            if (!sel) begin
              dir_x <= dx[rob_pkg::DIFF_W-1] ? -$signed(q_dir) : $signed(q_dir);
              sel   <= 1'b1;
            end else begin
              dir_y <= dy[rob_pkg::DIFF_W-1] ? -$signed(q_dir) : $signed(q_dir);
              state <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          k <= k + 4'd1;
          if (k != 4'd0) begin
            if (!j[0]) begin
              acc <= pe;
            end else begin
              case (j[2:1])
                2'd0:    ex <= acc + pe;
                2'd1:    ey <= acc - pe;
                2'd2:    px <= rob_pkg::P_W'(acc + pe);
                default: py <= rob_pkg::P_W'(acc - pe);
              endcase
            end
          end
          if (k == 4'd8) begin
            sel   <= 1'b0;
            state <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (p_sel == '0) begin
            // Ray parallel to this slab: either always inside or a miss.
            if (outside) begin
              state <= S_IDLE;
            end else if (!sel) begin
              lo_x <= -rob_pkg::T_LIMIT;
              hi_x <= rob_pkg::T_LIMIT;
              sel  <= 1'b1;
            end else begin
              lo_y  <= -rob_pkg::T_LIMIT;
              hi_y  <= rob_pkg::T_LIMIT;
              state <= S_DECIDE;
            end
          end else begin
            sub   <= 1'b0;
            state <= S_SLABDIV;
          end
        end
        S_SLABDIV: begin
          if (div_rsp.done) begin
            if (!sub) begin
              ta  <= t_val;
              sub <= 1'b1;
            end else if (!sel) begin
              lo_x  <= t_lo;
              hi_x  <= t_hi;
              sel   <= 1'b1;
              state <= S_AXIS;
            end else begin
              lo_y  <= t_lo;
              hi_y  <= t_hi;
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (take_hit) begin
            best_distance <= t_hit[rob_pkg::BEST_W-1:0];
            dist_r        <= t_hit[rob_pkg::DIST_W-1:0];
            best_box      <= idx;
            any_hit       <= 1'b1;
            k             <= '0;
            state         <= S_POINT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_POINT: begin
          k <= k + 4'd1;
          if (k == 4'd1) begin
            best_point_x <= place(prod, origin_x);
          end else if (k == 4'd2) begin
            best_point_y <= place(prod, origin_y);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ray_obb_nearest_hit_unit.sv -----
`default_nettype none

// Nearest hit of a 2D ray segment against a stream of oriented boxes. A query
// is a begin word carrying the ray, any number of box words, and a finish word
// that produces one result word: the hit flag, the order number of the nearest
// blocking box, the distance and the hit point (all zero when nothing was hit).
// Positions are Q16.8, distances Q15.8 and axis components Q2.14. Words enter
// through a two-entry queue, so up to two words are taken while the engine is
// busy or a result waits in its output register. The work runs on one shared
// bit-serial divider of 25 steps and one shared multiplier: a begin word does a
// 25-step square root and two divisions, or no division when the ray has zero
// length. A box that is tested takes eight multiplies and four divisions, and
// two more multiplies for the hit point when it becomes the nearest; each box
// axis that is parallel to the ray skips its two divisions. A box that is not
// blocking or comes with a zero-length ray only takes its order number as it
// is taken, and a finish word is taken once the output register is free. Box
// order numbers saturate at 1023, and a box at the same distance as the kept
// one does not replace it.
module ray_obb_nearest_hit_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [1:0]                       action,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_start_x,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_start_y,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_end_x,
  input  wire logic signed [rob_pkg::POS_W-1:0] ray_end_y,
  input  wire logic signed [rob_pkg::POS_W-1:0] box_center_x,
  input  wire logic signed [rob_pkg::POS_W-1:0] box_center_y,
  input  wire logic [rob_pkg::EXT_W-1:0]        box_width,
  input  wire logic [rob_pkg::EXT_W-1:0]        box_height,
  input  wire logic signed [rob_pkg::AX_W-1:0]  axis_cos,
  input  wire logic signed [rob_pkg::AX_W-1:0]  axis_sin,
  input  wire logic                             box_blocks,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic                                  hit_found,
  output logic [rob_pkg::IDX_W-1:0]             hit_index,
  output logic [rob_pkg::DIST_W-1:0]            hit_distance,
  output logic signed [rob_pkg::POS_W-1:0]      hit_point_x,
  output logic signed [rob_pkg::POS_W-1:0]      hit_point_y
);

  logic              q_valid;
  rob_pkg::item_t    q_item;
  logic              q_pop;
  logic              out_free;
  rob_pkg::res_t     res;
  rob_pkg::div_req_t div_req;
  rob_pkg::div_rsp_t div_rsp;

  rob_front u_front (
    .clk          (clk),
    .rst          (rst),
    .valid        (item_valid),
    .stall        (item_stall),
    .action       (action),
    .ray_start_x  (ray_start_x),
    .ray_start_y  (ray_start_y),
    .ray_end_x    (ray_end_x),
    .ray_end_y    (ray_end_y),
    .box_center_x (box_center_x),
    .box_center_y (box_center_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .axis_cos     (axis_cos),
    .axis_sin     (axis_sin),
    .box_blocks   (box_blocks),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  rob_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rob_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .res      (res),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  // The output register may be refilled in the cycle its word is taken.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      hit_found    <= res.found;
      hit_index    <= res.index;
      hit_distance <= res.distance;
      hit_point_x  <= res.point_x;
      hit_point_y  <= res.point_y;
    end
  end

endmodule

`default_nettype wire
